@@ design/bblru_pkg.sv @@
// ----------------------------------------------------------------------------
// bblru_pkg
// Shared constants and types of the byte-budget recency queue.
// ----------------------------------------------------------------------------
package bblru_pkg;

  localparam int NUM_CHUNKS = 32;
  localparam int NODES      = NUM_CHUNKS + 1;
  localparam int NODE_W     = $clog2(NODES);
  localparam int CADDR_W    = $clog2(NUM_CHUNKS);
  localparam int CHUNK_W    = 5;
  localparam int SIZE_W     = 32;
  localparam int TOT_W      = 37;
  localparam int BUD_W      = 40;
  localparam int APB_AW     = 4;
  localparam int APB_DW     = 64;
  localparam int LINK_W     = 2 * NODE_W;

  localparam logic [NODE_W-1:0] HEAD = NODE_W'(NUM_CHUNKS);

  localparam logic [APB_AW-4:0] REG_BUDGET = '0;

  typedef enum logic [2:0] {
    EV_FILLED     = 3'd0,
    EV_PROMOTED   = 3'd1,
    EV_NOT_FAULT  = 3'd2,
    EV_EVICTED    = 3'd3,
    EV_DEMOTED    = 3'd4,
    EV_FORGOTTEN  = 3'd5,
    EV_FORGET_IGN = 3'd6
  } event_kind_e;

  typedef enum logic {
    CMD_TOUCH  = 1'b0,
    CMD_FORGET = 1'b1
  } command_e;

  typedef struct packed {
    logic [NODE_W-1:0] next;
    logic [NODE_W-1:0] prev;
  } link_t;

endpackage

@@ design/bblru_if.sv @@
// ----------------------------------------------------------------------------
// bblru_item_if / bblru_event_if
// Valid/ready channels for command items and result events.
// ----------------------------------------------------------------------------
interface bblru_item_if;
  logic        valid;
  logic        ready;
  logic        command;
  logic [4:0]  chunk_index;
  logic [31:0] chunk_bytes;

  modport source (output valid, command, chunk_index, chunk_bytes, input ready);
  modport sink   (input valid, command, chunk_index, chunk_bytes, output ready);
endinterface

interface bblru_event_if;
  logic        valid;
  logic        ready;
  logic [2:0]  event_kind;
  logic [4:0]  event_chunk;
  logic [36:0] total_resident;
  logic        last;

  modport source (output valid, event_kind, event_chunk, total_resident, last, input ready);
  modport sink   (input valid, event_kind, event_chunk, total_resident, last, output ready);
endinterface

@@ design/bblru_ram.sv @@
// ----------------------------------------------------------------------------
// bblru_ram
// Generic simple dual-port RAM with a registered read.
// ----------------------------------------------------------------------------
module bblru_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule

@@ design/bblru_cfg.sv @@
// ----------------------------------------------------------------------------
// bblru_cfg
// APB register file holding the resident byte budget.
// ----------------------------------------------------------------------------
module bblru_cfg (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [bblru_pkg::APB_AW-1:0]      paddr,
  input  logic [bblru_pkg::APB_DW-1:0]      pwdata,
  output logic [bblru_pkg::APB_DW-1:0]      prdata,
  output logic                              pready,
  output logic [bblru_pkg::BUD_W-1:0]       budget_o
);

  logic [bblru_pkg::BUD_W-1:0] budget_q;
  logic [bblru_pkg::APB_AW-4:0] reg_idx;

  assign reg_idx  = paddr[bblru_pkg::APB_AW-1:3];
  assign pready   = 1'b1;
  assign budget_o = budget_q;
  assign prdata   = (reg_idx == bblru_pkg::REG_BUDGET) ?
                    bblru_pkg::APB_DW'(budget_q) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      budget_q <= '0;
    end else if (psel && penable && pwrite && reg_idx == bblru_pkg::REG_BUDGET) begin
      budget_q <= pwdata[bblru_pkg::BUD_W-1:0];
    end
  end

endmodule

@@ design/bblru_core.sv @@
// ----------------------------------------------------------------------------
// bblru_core
// Sequencer that walks the linked recency queue held in RAM, with fills,
// promotions, evictions, demotions and forgets as read-modify-write steps.
// ----------------------------------------------------------------------------
module bblru_core (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic [bblru_pkg::BUD_W-1:0] budget_i,
  bblru_item_if.sink                  item_i,
  bblru_event_if.source               event_o
);

  localparam int NW = bblru_pkg::NODE_W;
  localparam int CW = bblru_pkg::CADDR_W;
  localparam int TW = bblru_pkg::TOT_W;

  typedef enum logic [4:0] {
    ST_IDLE, ST_EMIT,
    ST_RM_RD, ST_RM_GOT, ST_RM_WP, ST_RM_RX, ST_RM_WX,
    ST_PU_RH, ST_PU_GH, ST_PU_WF, ST_PU_RH2, ST_PU_WH,
    ST_EV_CHK, ST_EV_GOT, ST_EV_DONE,
    ST_DM_CHK, ST_DM_GOT, ST_DM_RD, ST_DM_UPD,
    ST_FG_DONE
  } state_e;

  state_e state_q, em_ret_q, rm_ret_q;

  logic [bblru_pkg::NUM_CHUNKS-1:0] res_flag_q, cold_q;
  logic [bblru_pkg::NODES-1:0]      lk_vld_q;
  logic [NW-1:0] mid_q, c_q, tgt_q, p_q, x_q, first_q, lk_raddr_q;
  logic [TW-1:0] hot_q, res_q;
  logic [bblru_pkg::SIZE_W-1:0] csz_q;
  logic rm_drop_q, em_last_q;
  bblru_pkg::event_kind_e pend_kind_q;
  logic [bblru_pkg::CHUNK_W-1:0] pend_chunk_q;

  logic ov_q, out_last_q;
  bblru_pkg::event_kind_e out_kind_q;
  logic [bblru_pkg::CHUNK_W-1:0] out_chunk_q;
  logic [TW-1:0] out_total_q;

  logic lk_we;
  logic [NW-1:0] lk_waddr, lk_raddr;
  bblru_pkg::link_t lk_wdata, lk_rd;
  logic [bblru_pkg::LINK_W-1:0] lk_raw;
  logic sz_we;
  logic [CW-1:0] sz_waddr, sz_raddr;
  logic [bblru_pkg::SIZE_W-1:0] sz_rdata;

  logic [CW-1:0] in_c, tc, cc, mc;
  logic in_range, budget_on, emit_fire;

  assign in_c      = CW'(item_i.chunk_index);
  assign in_range  = int'(item_i.chunk_index) < bblru_pkg::NUM_CHUNKS;
  assign tc        = tgt_q[CW-1:0];
  assign cc        = c_q[CW-1:0];
  assign mc        = mid_q[CW-1:0];
  assign budget_on = budget_i != '0;
  assign emit_fire = (state_q == ST_EMIT) && (!ov_q || event_o.ready);

  assign lk_rd = lk_vld_q[lk_raddr_q] ? bblru_pkg::link_t'(lk_raw) :
                 bblru_pkg::link_t'{next: lk_raddr_q, prev: lk_raddr_q};

  assign item_i.ready           = (state_q == ST_IDLE);
  assign event_o.valid          = ov_q;
  assign event_o.event_kind     = out_kind_q;
  assign event_o.event_chunk    = out_chunk_q;
  assign event_o.total_resident = out_total_q;
  assign event_o.last           = out_last_q;

  always_comb begin
    lk_we    = 1'b0;
    lk_waddr = bblru_pkg::HEAD;
    lk_wdata = '{next: bblru_pkg::HEAD, prev: bblru_pkg::HEAD};
    lk_raddr = bblru_pkg::HEAD;
    sz_we    = 1'b0;
    sz_waddr = in_c;
    sz_raddr = tc;
    case (state_q)
      ST_IDLE: begin
        sz_we = item_i.valid && in_range && item_i.command == bblru_pkg::CMD_TOUCH &&
                !res_flag_q[in_c];
      end
      ST_RM_RD: begin
        lk_raddr = tgt_q;
      end
      ST_RM_GOT: begin
        lk_we    = 1'b1;
        lk_waddr = tgt_q;
        lk_wdata = '{next: tgt_q, prev: tgt_q};
        lk_raddr = lk_rd.prev;
      end
      ST_RM_WP: begin
        lk_we    = 1'b1;
        lk_waddr = p_q;
        lk_wdata = '{next: x_q, prev: lk_rd.prev};
      end
      ST_RM_RX: begin
        lk_raddr = x_q;
      end
      ST_RM_WX: begin
        lk_we    = 1'b1;
        lk_waddr = x_q;
        lk_wdata = '{next: lk_rd.next, prev: p_q};
      end
      ST_PU_GH: begin
        lk_we    = 1'b1;
        lk_waddr = c_q;
        lk_wdata = '{next: lk_rd.next, prev: bblru_pkg::HEAD};
        lk_raddr = lk_rd.next;
      end
      ST_PU_WF: begin
        lk_we    = 1'b1;
        lk_waddr = first_q;
        lk_wdata = '{next: lk_rd.next, prev: c_q};
      end
      ST_PU_WH: begin
        lk_we    = 1'b1;
        lk_waddr = bblru_pkg::HEAD;
        lk_wdata = '{next: c_q, prev: lk_rd.prev};
      end
      ST_DM_RD: begin
        lk_raddr = mid_q;
        sz_raddr = mc;
      end
      default: begin
      end
    endcase
  end

  bblru_ram #(.WIDTH(bblru_pkg::LINK_W), .DEPTH(bblru_pkg::NODES)) u_link_ram (
    .clk_i   (clk_i),
    .we_i    (lk_we),
    .waddr_i (lk_waddr),
    .wdata_i (lk_wdata),
    .raddr_i (lk_raddr),
    .rdata_o (lk_raw)
  );

  bblru_ram #(.WIDTH(bblru_pkg::SIZE_W), .DEPTH(bblru_pkg::NUM_CHUNKS)) u_size_ram (
    .clk_i   (clk_i),
    .we_i    (sz_we),
    .waddr_i (sz_waddr),
    .wdata_i (item_i.chunk_bytes),
    .raddr_i (sz_raddr),
    .rdata_o (sz_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      em_ret_q     <= ST_IDLE;
      rm_ret_q     <= ST_IDLE;
      em_last_q    <= 1'b0;
      rm_drop_q    <= 1'b0;
      res_flag_q   <= '0;
      cold_q       <= '0;
      lk_vld_q     <= '0;
      mid_q        <= bblru_pkg::HEAD;
      hot_q        <= '0;
      res_q        <= '0;
      ov_q         <= 1'b0;
      lk_raddr_q   <= bblru_pkg::HEAD;
      c_q          <= '0;
      tgt_q        <= '0;
      p_q          <= '0;
      x_q          <= '0;
      first_q      <= '0;
      csz_q        <= '0;
      pend_kind_q  <= bblru_pkg::EV_NOT_FAULT;
      pend_chunk_q <= '0;
      out_kind_q   <= bblru_pkg::EV_NOT_FAULT;
      out_chunk_q  <= '0;
      out_total_q  <= '0;
      out_last_q   <= 1'b0;
    end else begin
      lk_raddr_q <= lk_raddr;
      if (lk_we) begin
        lk_vld_q[lk_waddr] <= 1'b1;
      end
      if (ov_q && event_o.ready && !emit_fire) begin
        ov_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (item_i.valid) begin
            c_q          <= NW'(item_i.chunk_index);
            tgt_q        <= NW'(item_i.chunk_index);
            csz_q        <= item_i.chunk_bytes;
            pend_chunk_q <= item_i.chunk_index;
            em_last_q    <= 1'b1;
            em_ret_q     <= ST_IDLE;
            if (item_i.command == bblru_pkg::CMD_FORGET) begin
              if (in_range && res_flag_q[in_c]) begin
                rm_drop_q <= 1'b1;
                rm_ret_q  <= ST_FG_DONE;
                state_q   <= ST_RM_RD;
              end else begin
                pend_kind_q <= bblru_pkg::EV_FORGET_IGN;
                state_q     <= ST_EMIT;
              end
            end else if (!in_range || (res_flag_q[in_c] && !cold_q[in_c])) begin
              pend_kind_q <= bblru_pkg::EV_NOT_FAULT;
              state_q     <= ST_EMIT;
            end else if (res_flag_q[in_c]) begin
              pend_kind_q <= bblru_pkg::EV_PROMOTED;
              rm_drop_q   <= 1'b0;
              rm_ret_q    <= ST_PU_RH;
              state_q     <= ST_RM_RD;
            end else begin
              pend_kind_q <= bblru_pkg::EV_FILLED;
              res_q       <= res_q + TW'(item_i.chunk_bytes);
              state_q     <= ST_PU_RH;
            end
          end
        end
        ST_EMIT: begin
          if (emit_fire) begin
            ov_q        <= 1'b1;
            out_kind_q  <= pend_kind_q;
            out_chunk_q <= pend_chunk_q;
            out_total_q <= res_q;
            out_last_q  <= em_last_q;
            state_q     <= em_ret_q;
          end
        end
        ST_RM_RD: state_q <= ST_RM_GOT;
        ST_RM_GOT: begin
          p_q <= lk_rd.prev;
          x_q <= lk_rd.next;
          if (mid_q == tgt_q) begin
            mid_q <= lk_rd.prev;
          end
          if (!cold_q[tc]) begin
            hot_q <= hot_q - TW'(sz_rdata);
          end
          if (rm_drop_q) begin
            res_q <= res_q - TW'(sz_rdata);
          end else begin
            csz_q <= sz_rdata;
          end
          res_flag_q[tc] <= 1'b0;
          state_q        <= ST_RM_WP;
        end
        ST_RM_WP: state_q <= ST_RM_RX;
        ST_RM_RX: state_q <= ST_RM_WX;
        ST_RM_WX: state_q <= rm_ret_q;
        ST_PU_RH: state_q <= ST_PU_GH;
        ST_PU_GH: begin
          first_q        <= lk_rd.next;
          res_flag_q[cc] <= 1'b1;
          cold_q[cc]     <= 1'b0;
          hot_q          <= hot_q + TW'(csz_q);
          if (mid_q == bblru_pkg::HEAD) begin
            mid_q <= c_q;
          end
          state_q <= ST_PU_WF;
        end
        ST_PU_WF:  state_q <= ST_PU_RH2;
        ST_PU_RH2: state_q <= ST_PU_WH;
        ST_PU_WH:  state_q <= ST_EV_CHK;
        ST_EV_CHK: begin
          if (budget_on && bblru_pkg::BUD_W'(res_q) > budget_i) begin
            state_q <= ST_EV_GOT;
          end else begin
            state_q <= ST_DM_CHK;
          end
        end
        ST_EV_GOT: begin
          if (lk_rd.prev == bblru_pkg::HEAD || lk_rd.prev == c_q) begin
            state_q <= ST_DM_CHK;
          end else begin
            tgt_q     <= lk_rd.prev;
            rm_drop_q <= 1'b1;
            rm_ret_q  <= ST_EV_DONE;
            em_last_q <= 1'b0;
            em_ret_q  <= ST_RM_RD;
            state_q   <= ST_EMIT;
          end
        end
        ST_EV_DONE: begin
          pend_kind_q  <= bblru_pkg::EV_EVICTED;
          pend_chunk_q <= bblru_pkg::CHUNK_W'(tgt_q);
          state_q      <= ST_EV_CHK;
        end
        ST_DM_CHK: begin
          if (budget_on && hot_q > (res_q >> 1)) begin
            state_q <= ST_DM_GOT;
          end else begin
            em_last_q <= 1'b1;
            em_ret_q  <= ST_IDLE;
            state_q   <= ST_EMIT;
          end
        end
        ST_DM_GOT: begin
          em_last_q <= (mid_q == bblru_pkg::HEAD || mid_q == lk_rd.next);
          em_ret_q  <= (mid_q == bblru_pkg::HEAD || mid_q == lk_rd.next) ? ST_IDLE : ST_DM_RD;
          state_q   <= ST_EMIT;
        end
        ST_DM_RD: state_q <= ST_DM_UPD;
        ST_DM_UPD: begin
          cold_q[mc]   <= 1'b1;
          hot_q        <= hot_q - TW'(sz_rdata);
          pend_kind_q  <= bblru_pkg::EV_DEMOTED;
          pend_chunk_q <= bblru_pkg::CHUNK_W'(mid_q);
          mid_q        <= lk_rd.prev;
          state_q      <= ST_DM_CHK;
        end
        ST_FG_DONE: begin
          pend_kind_q <= bblru_pkg::EV_FORGOTTEN;
          em_last_q   <= 1'b1;
          em_ret_q    <= ST_IDLE;
          state_q     <= ST_EMIT;
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  a_hot_le_res: assert property (@(posedge clk_i) disable iff (!rst_ni)
    hot_q <= res_q) else $error("hot bytes exceed resident bytes");

  a_empty_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_IDLE && res_flag_q == '0 |-> res_q == '0)
    else $error("empty queue holds bytes");

  a_mid_head_cold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mid_q == bblru_pkg::HEAD |-> hot_q == '0) else $error("hot bytes without midpoint");

endmodule

@@ design/byte_budget_lru_with_cold_midpoint.sv @@
// ----------------------------------------------------------------------------
// byte_budget_lru_with_cold_midpoint
// Byte-budget recency queue with a hot/cold midpoint and APB budget register.
// ----------------------------------------------------------------------------
// One item at a time: a new item is taken only in idle, once the final event
// of the last item has been loaded into the output register. A fill or
// promotion gives its result first, then one event per eviction and per
// demotion, the last one flagged; output stalls can hold each event.
// Reset clears flags and totals at once; link entries read as self-pointing
// until written, with no sweep.
module byte_budget_lru_with_cold_midpoint (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [bblru_pkg::APB_AW-1:0] paddr,
  input  logic [bblru_pkg::APB_DW-1:0] pwdata,
  output logic [bblru_pkg::APB_DW-1:0] prdata,
  output logic                         pready,
  bblru_item_if.sink                   item_i,
  bblru_event_if.source                event_o
);

  logic [bblru_pkg::BUD_W-1:0] budget;

  bblru_cfg u_cfg (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready),
    .budget_o (budget)
  );

  bblru_core u_core (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .budget_i (budget),
    .item_i   (item_i),
    .event_o  (event_o)
  );

endmodule
